// File: src/bfad_pkg.sv
// Shared types and constants for the bright frame anomaly detector.
package bfad_pkg;

  // Fixed widths of the channel fields.
  localparam int PIX_W    = 8;
  localparam int SIGMA_W  = 8;
  localparam int K2_W     = 2 * SIGMA_W;
  localparam int STAT_W   = 24;
  localparam int FRAMES_W = 32;

  // Sum of squared deviations and the shared multiplier.
  localparam int SUM_W  = 64;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 8'd10;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_DIV_MEAN,
    S_WAIT_MEAN,
    S_MUL_PROD,
    S_ADD_SUM,
    S_DIV_VAR,
    S_WAIT_VAR,
    S_MUL_DSQ,
    S_MUL_KLO,
    S_MUL_KHI,
    S_CMP,
    S_LOAD
  } state_t;

  // Operand and destination choice of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_PROD,
    MUL_DSQ,
    MUL_KLO,
    MUL_KHI
  } mul_op_t;

  // Operand choice of the shared divider.
  typedef enum logic {
    DIV_MEAN,
    DIV_VAR
  } div_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_ready;
    logic    first_load;
    logic    div_start;
    div_op_t div_op;
    logic    mean_upd;
    logic    sum_add;
    logic    var_load;
    mul_op_t mul_op;
    logic    anom_load;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eof_fire;
    logic count_zero;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// File: src/bfad_if.sv
// Stream interfaces for the pixel input channel and the result channel.
interface bfad_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       end_of_frame;

  modport source (output valid, output pixel_value, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_value, input end_of_frame, output ready);
endinterface

interface bfad_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_peak;
  logic [23:0] mean_of_peaks;
  logic [23:0] peak_variance;
  logic        anomaly;
  logic [31:0] frames_seen;

  modport source (output valid, output frame_peak, output mean_of_peaks,
                  output peak_variance, output anomaly, output frames_seen, input ready);
  modport sink   (input valid, input frame_peak, input mean_of_peaks,
                  input peak_variance, input anomaly, input frames_seen, output ready);
endinterface

// File: src/bfad_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module bfad_div #(
  parameter int DVD_W = 64,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  // Control: busy from a start until every dividend bit has been shifted through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits enter at the bottom as dividend bits leave the top.
  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign busy_o     = busy_r;
  assign quotient_o = quo_r;

endmodule

// File: src/bfad_ctrl.sv
// Controller state machine that sequences one statistics update per frame.
module bfad_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  bfad_pkg::sts_t sts_i,
  output bfad_pkg::cmd_t cmd_o
);
  import bfad_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (sts_i.eof_fire) begin
          state_nxt = sts_i.count_zero ? S_FIRST : S_DIV_MEAN;
        end
      end
      S_FIRST:     state_nxt = S_MUL_DSQ;
      S_DIV_MEAN:  state_nxt = S_WAIT_MEAN;
      S_WAIT_MEAN: begin
        if (!sts_i.div_busy) begin
          state_nxt = S_MUL_PROD;
        end
      end
      S_MUL_PROD:  state_nxt = S_ADD_SUM;
      S_ADD_SUM:   state_nxt = S_DIV_VAR;
      S_DIV_VAR:   state_nxt = S_WAIT_VAR;
      S_WAIT_VAR: begin
        if (!sts_i.div_busy) begin
          state_nxt = S_MUL_DSQ;
        end
      end
      S_MUL_DSQ:   state_nxt = S_MUL_KLO;
      S_MUL_KLO:   state_nxt = S_MUL_KHI;
      S_MUL_KHI:   state_nxt = S_CMP;
      S_CMP:       state_nxt = S_LOAD;
      S_LOAD: begin
        if (sts_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o.in_ready   = 1'b0;
    cmd_o.first_load = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.div_op     = DIV_MEAN;
    cmd_o.mean_upd   = 1'b0;
    cmd_o.sum_add    = 1'b0;
    cmd_o.var_load   = 1'b0;
    cmd_o.mul_op     = MUL_NONE;
    cmd_o.anom_load  = 1'b0;
    cmd_o.out_load   = 1'b0;
    unique case (state_r)
      S_IDLE:      cmd_o.in_ready = 1'b1;
      S_FIRST:     cmd_o.first_load = 1'b1;
      S_DIV_MEAN:  cmd_o.div_start = 1'b1;
      S_WAIT_MEAN: cmd_o.mean_upd = !sts_i.div_busy;
      S_MUL_PROD:  cmd_o.mul_op = MUL_PROD;
      S_ADD_SUM:   cmd_o.sum_add = 1'b1;
      S_DIV_VAR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_VAR;
      end
      S_WAIT_VAR:  cmd_o.var_load = !sts_i.div_busy;
      S_MUL_DSQ:   cmd_o.mul_op = MUL_DSQ;
      S_MUL_KLO:   cmd_o.mul_op = MUL_KLO;
      S_MUL_KHI:   cmd_o.mul_op = MUL_KHI;
      S_CMP:       cmd_o.anom_load = 1'b1;
      S_LOAD:      cmd_o.out_load = sts_i.out_free;
      default:     cmd_o.in_ready = 1'b0;
    endcase
  end

`ifndef SYNTH
  // The divider is never restarted while it is still working.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  // A result is only loaded when the output register can take it.
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a pending result");

  // An end-of-frame transfer always starts the update sequence.
  a_eof_starts: assert property (@(posedge clk) disable iff (!rst_n)
    sts_i.eof_fire |=> (state_r == S_FIRST || state_r == S_DIV_MEAN))
    else $error("end of frame did not start an update");
`endif

endmodule

// File: src/bfad_dp.sv
// Datapath: frame peak tracker, Welford statistics, shared multiplier and divider.
module bfad_dp #(
  parameter int COUNT_BITS         = 32,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bfad_pkg::SIGMA_W-1:0] cfg_wdata,
  input  bfad_pkg::cmd_t               cmd_i,
  output bfad_pkg::sts_t               sts_o,
  bfad_pix_if.sink                     in_ch,
  bfad_res_if.source                   out_ch
);
  import bfad_pkg::*;

  localparam int FW    = MEAN_FRACTION_BITS;
  localparam int MW    = PIX_W + FW;
  localparam int CW    = COUNT_BITS;
  localparam int VSH   = 2 * FW - 8;
  localparam int EXT_W = (CW > FRAMES_W) ? CW : FRAMES_W;
  localparam int VK_W  = PROD_W + MUL_W;
  localparam int MQ_W  = MW + 16;

  // Architectural state.
  logic [PIX_W-1:0]   cur_peak_r;
  logic [CW-1:0]      n_r;
  logic [MW-1:0]      mean_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SIGMA_W-1:0] sigma_r;

  // Working registers of one update.
  logic [PIX_W-1:0]   peak_r;
  logic [MW-1:0]      d_r;
  logic               sign_r;
  logic [SUM_W-1:0]   var_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  dsq_r;
  logic [PROD_W-1:0]  mlo_r;
  logic [PROD_W-1:0]  mhi_r;
  logic [K2_W-1:0]    k2_r;
  logic               anom_r;

  // Output register.
  logic               out_valid_r;
  logic [PIX_W-1:0]   o_peak_r;
  logic [STAT_W-1:0]  o_mean_r;
  logic [STAT_W-1:0]  o_var_r;
  logic               o_anom_r;
  logic [FRAMES_W-1:0] o_frames_r;

  logic               fire;
  logic [PIX_W-1:0]   pix_max;
  logic [MW-1:0]      xf;
  logic               x_ge;
  logic               x_gt;
  logic [MW-1:0]      absd;
  logic [SUM_W-1:0]   div_dvd;
  logic [CW-1:0]      div_dvs;
  logic               div_busy;
  logic [SUM_W-1:0]   div_quo;
  logic [MW-1:0]      q_mw;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  product;
  logic [SUM_W:0]     sum_ext;
  logic [VK_W-1:0]    vk;
  logic [MQ_W-1:0]    mq;
  logic [SUM_W-1:0]   vsh;
  logic [EXT_W-1:0]   n_ext;

  // Input transfers and peak tracking.
  assign in_ch.ready = cmd_i.in_ready;
  assign fire        = in_ch.valid && cmd_i.in_ready;
  assign pix_max     = (in_ch.pixel_value > cur_peak_r) ? in_ch.pixel_value : cur_peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_peak_r <= '0;
      n_r        <= '0;
    end else if (fire) begin
      cur_peak_r <= in_ch.end_of_frame ? '0 : pix_max;
      if (in_ch.end_of_frame && (n_r != {CW{1'b1}})) begin
        n_r <= n_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_ch.end_of_frame) begin
      peak_r <= pix_max;
    end
  end

  // Configuration register and its square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RESET;
    end else if (cfg_we) begin
      sigma_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    k2_r <= K2_W'(sigma_r) * K2_W'(sigma_r);
  end

  // Peak in mean format and its distance to the current mean.
  assign xf   = {peak_r, {FW{1'b0}}};
  assign x_ge = xf >= mean_r;
  assign x_gt = xf > mean_r;
  assign absd = x_ge ? (xf - mean_r) : (mean_r - xf);

  // Shared divider: d / n for the mean, S / (n - 1) for the variance.
  assign div_dvd = (cmd_i.div_op == DIV_VAR) ? sum_r : SUM_W'(absd);
  assign div_dvs = (cmd_i.div_op == DIV_VAR) ? (n_r - CW'(1)) : n_r;
  assign q_mw    = div_quo[MW-1:0];

  bfad_div #(
    .DVD_W (SUM_W),
    .DVS_W (CW)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd_i.div_start && (cmd_i.div_op == DIV_MEAN)) begin
      d_r    <= absd;
      sign_r <= x_ge;
    end
  end

  // Mean and sum of squared deviations.
  assign sum_ext = {1'b0, sum_r} + {1'b0, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      sum_r  <= '0;
    end else if (cmd_i.first_load) begin
      mean_r <= xf;
      sum_r  <= '0;
    end else begin
      if (cmd_i.mean_upd) begin
        mean_r <= sign_r ? (mean_r + q_mw) : (mean_r - q_mw);
      end
      if (cmd_i.sum_add) begin
        sum_r <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.first_load) begin
      var_r <= '0;
    end else if (cmd_i.var_load) begin
      var_r <= div_quo;
    end
  end

  // Shared multiplier with its result written straight into a register.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      MUL_PROD: begin
        mul_a = MUL_W'(d_r);
        mul_b = MUL_W'(absd);
      end
      MUL_DSQ: begin
        mul_a = MUL_W'(absd);
        mul_b = MUL_W'(absd);
      end
      MUL_KLO: begin
        mul_a = var_r[MUL_W-1:0];
        mul_b = MUL_W'(k2_r);
      end
      MUL_KHI: begin
        mul_a = var_r[SUM_W-1:MUL_W];
        mul_b = MUL_W'(k2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  always_ff @(posedge clk) begin
    unique case (cmd_i.mul_op)
      MUL_PROD: prod_r <= product;
      MUL_DSQ:  dsq_r  <= product;
      MUL_KLO:  mlo_r  <= product;
      MUL_KHI:  mhi_r  <= product;
      default:  prod_r <= prod_r;
    endcase
  end

  // Anomaly test: peak above mean and variance * K^2 below diff^2.
  assign vk = {mhi_r, {MUL_W{1'b0}}} + VK_W'(mlo_r);

  always_ff @(posedge clk) begin
    if (cmd_i.anom_load) begin
      anom_r <= x_gt && ((k2_r == '0) || (vk < VK_W'(dsq_r)));
    end
  end

  // Result formatting.
  assign mq    = {mean_r, 16'b0} >> FW;
  assign vsh   = var_r >> VSH;
  assign n_ext = EXT_W'(n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      o_peak_r   <= peak_r;
      o_mean_r   <= mq[STAT_W-1:0];
      o_var_r    <= (vsh > SUM_W'(24'hFFFFFF)) ? {STAT_W{1'b1}} : vsh[STAT_W-1:0];
      o_anom_r   <= anom_r;
      o_frames_r <= (n_ext > EXT_W'(32'hFFFF_FFFF)) ? {FRAMES_W{1'b1}} : n_ext[FRAMES_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_peak    = o_peak_r;
  assign out_ch.mean_of_peaks = o_mean_r;
  assign out_ch.peak_variance = o_var_r;
  assign out_ch.anomaly       = o_anom_r;
  assign out_ch.frames_seen   = o_frames_r;

  // Status back to the controller.
  assign sts_o.eof_fire   = fire && in_ch.end_of_frame;
  assign sts_o.count_zero = (n_r == '0);
  assign sts_o.div_busy   = div_busy;
  assign sts_o.out_free   = !out_valid_r || out_ch.ready;

`ifndef SYNTH
  // A raised flag always belongs to a peak strictly above the new mean.
  a_anom_above_mean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.anom_load |=> (!anom_r || x_gt))
    else $error("anomaly flagged for a peak not above the mean");
`endif

endmodule

// File: src/bright_frame_anomaly_detector.sv
// Top level of the bright frame anomaly detector.
//
// Pixel bytes arrive on in_ch, one transfer per byte; end_of_frame marks the
// last byte of a frame. The block tracks the largest byte of the frame and,
// on the marked byte, folds that peak into running mean and variance
// statistics, then presents one result on out_ch: the peak, the mean (Q8.16),
// the sample variance (Q16.8), the anomaly flag and the frame count.
// A frame streams at one byte per clock while in_ch.ready is high. After a
// marked byte in_ch.ready stays low while the update runs: two passes of the
// shared radix-2 divider (mean step, then variance) plus the multiplier
// steps; the first frame skips both divider passes. The result sits in an
// output register, so bytes of the next frame are taken while it waits; a
// marked byte that arrives with a result still pending holds the new result
// until out_ch.ready takes the old one. The user must write sigma_multiple
// through cfg_we/cfg_wdata only while the block is idle; the block itself
// does not enforce this. Synchronous reset clears the peak, count, mean and
// sum, sets sigma_multiple to 10 and drops out_ch.valid.
module bright_frame_anomaly_detector #(
  parameter int COUNT_BITS         = 32,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bfad_pkg::SIGMA_W-1:0] cfg_wdata,
  bfad_pix_if.sink                     in_ch,
  bfad_res_if.source                   out_ch
);
  import bfad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  bfad_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // Arithmetic and storage.
  bfad_dp #(
    .COUNT_BITS         (COUNT_BITS),
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule
